/* src/indexed_sprite_blitter_assert.svh */
// Assertion macros shared by the sprite blitter RTL files.
`ifndef INDEXED_SPRITE_BLITTER_ASSERT_SVH
`define INDEXED_SPRITE_BLITTER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, reset-qualified
`define ISB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isb assertion failed");
// next-cycle implication, reset-qualified
`define ISB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isb assertion failed");
`else
`define ISB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ISB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* src/isb_pkg.sv */
// Types and constants of the palettized sprite blitter.
package isb_pkg;

    // default sizing
    localparam int NUM_PALETTES_DEF    = 256;
    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int MAX_IMAGE_DIM_DEF   = 4096;
    localparam int MAX_CANVAS_DEF      = 8192;

    // front-to-back queue
    localparam int QUEUE_DEPTH = 4;

    // world coordinate width: 16-bit signed position plus image offset, minus origin
    localparam int COORD_W = 18;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X      = 2'd0,
        CFG_ORIGIN_Y      = 2'd1,
        CFG_CANVAS_WIDTH  = 2'd2,
        CFG_CANVAS_HEIGHT = 2'd3
    } cfg_index_t;

    // input item kinds
    typedef enum logic [1:0] {
        KIND_PAL = 2'd0,
        KIND_OBJ = 2'd1,
        KIND_PIX = 2'd2
    } kind_t;

    // operations carried to the back end
    typedef enum logic [1:0] {
        OP_PAL = 2'd0,
        OP_OBJ = 2'd1,
        OP_PIX = 2'd2
    } op_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  palette_slot;
        logic [7:0]  entry;
        logic [14:0] color;
        logic [8:0]  pal_size;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [12:0] img_width;
        logic [12:0] img_height;
        logic        hflip;
        logic        vflip;
        logic [7:0]  pixel;
    } item_t;

    typedef struct packed {
        logic        is_status;
        logic        object_skipped;
        logic [12:0] dest_x;
        logic [12:0] dest_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } result_t;

    // live configuration
    typedef struct packed {
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [13:0] canvas_w;
        logic [13:0] canvas_h;
    } cfg_t;

    // one classified request in the queue
    typedef struct packed {
        op_t                op;
        logic [7:0]         slot;
        logic               slot_ok;
        logic               entry_ok;
        logic [7:0]         idx;
        logic [14:0]        color;
        logic [8:0]         size;
        logic [COORD_W-1:0] wx;
        logic [COORD_W-1:0] wy;
    } qentry_t;

    // 5-bit channel to 8 bits by replication
    function automatic logic [7:0] expand5(input logic [4:0] c);
        expand5 = {c, c[4:2]};
    endfunction

endpackage

/* src/isb_front.sv */
// Front end: object tracking, raster counters with flip, request classification.
module isb_front #(
    parameter int NUM_PALETTES    = isb_pkg::NUM_PALETTES_DEF,
    parameter int PALETTE_ENTRIES = isb_pkg::PALETTE_ENTRIES_DEF,
    parameter int MAX_IMAGE_DIM   = isb_pkg::MAX_IMAGE_DIM_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  isb_pkg::item_t  item,
    input  logic            q_full,
    output logic            q_wr,
    output isb_pkg::qentry_t q_entry
);

    localparam int DIM_W = $clog2(MAX_IMAGE_DIM);
    localparam int CW    = isb_pkg::COORD_W;

    // object state
    logic             active_reg, active_next;
    logic [7:0]       slot_reg, slot_next;
    logic             slot_ok_reg, slot_ok_next;
    logic [15:0]      px_reg, px_next;
    logic [15:0]      py_reg, py_next;
    logic [DIM_W-1:0] wm1_reg, wm1_next;
    logic [DIM_W-1:0] hm1_reg, hm1_next;
    logic             hf_reg, hf_next;
    logic             vf_reg, vf_next;

    // raster counters, plain and mirrored
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [DIM_W-1:0] colf_reg, colf_next;
    logic [DIM_W-1:0] rowf_reg, rowf_next;

    logic             accept;
    logic             slot_in_ok;
    logic [DIM_W-1:0] wm1_in;
    logic [DIM_W-1:0] hm1_in;
    logic [8:0]       size_in;

    assign accept     = push && !q_full;
    assign slot_in_ok = {1'b0, item.palette_slot} < 9'(NUM_PALETTES);

    // image size clamp to 1..MAX_IMAGE_DIM, kept as size minus one
    always_comb
    begin
        if (item.img_width == 13'd0)
            wm1_in = '0;
        else if (item.img_width > 13'(MAX_IMAGE_DIM))
            wm1_in = DIM_W'(MAX_IMAGE_DIM - 1);
        else
            wm1_in = DIM_W'(item.img_width - 13'd1);

        if (item.img_height == 13'd0)
            hm1_in = '0;
        else if (item.img_height > 13'(MAX_IMAGE_DIM))
            hm1_in = DIM_W'(MAX_IMAGE_DIM - 1);
        else
            hm1_in = DIM_W'(item.img_height - 13'd1);
    end

    // palette size saturates at the entry count
    assign size_in = (item.pal_size > 9'(PALETTE_ENTRIES)) ? 9'(PALETTE_ENTRIES)
                                                          : item.pal_size;

    // classification and counter stepping
    always_comb
    begin
        active_next  = active_reg;
        slot_next    = slot_reg;
        slot_ok_next = slot_ok_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        wm1_next     = wm1_reg;
        hm1_next     = hm1_reg;
        hf_next      = hf_reg;
        vf_next      = vf_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        colf_next    = colf_reg;
        rowf_next    = rowf_reg;

        q_wr             = 1'b0;
        q_entry.op       = isb_pkg::OP_PAL;
        q_entry.slot     = item.palette_slot;
        q_entry.slot_ok  = slot_in_ok;
        q_entry.entry_ok = {1'b0, item.entry} < 9'(PALETTE_ENTRIES);
        q_entry.idx      = item.entry;
        q_entry.color    = item.color;
        q_entry.size     = size_in;
        q_entry.wx       = {{(CW-16){px_reg[15]}}, px_reg} + CW'(colf_reg);
        q_entry.wy       = {{(CW-16){py_reg[15]}}, py_reg} + CW'(rowf_reg);

        unique case (item.kind)
            isb_pkg::KIND_PAL:
            begin
                // writes to a missing palette are dropped here
                q_wr = accept && slot_in_ok;
            end
            isb_pkg::KIND_OBJ:
            begin
                q_entry.op = isb_pkg::OP_OBJ;
                q_wr       = accept;
                if (accept)
                begin
                    active_next  = 1'b1;
                    slot_next    = item.palette_slot;
                    slot_ok_next = slot_in_ok;
                    px_next      = item.pos_x;
                    py_next      = item.pos_y;
                    wm1_next     = wm1_in;
                    hm1_next     = hm1_in;
                    hf_next      = item.hflip;
                    vf_next      = item.vflip;
                    col_next     = '0;
                    row_next     = '0;
                    colf_next    = item.hflip ? wm1_in : '0;
                    rowf_next    = item.vflip ? hm1_in : '0;
                end
            end
            isb_pkg::KIND_PIX:
            begin
                q_entry.op      = isb_pkg::OP_PIX;
                q_entry.slot    = slot_reg;
                q_entry.slot_ok = slot_ok_reg;
                q_entry.idx     = item.pixel;
                q_wr            = accept && active_reg;
                if (accept && active_reg)
                begin
                    if (col_reg == wm1_reg)
                    begin
                        // end of row
                        col_next  = '0;
                        colf_next = hf_reg ? wm1_reg : '0;
                        if (row_reg == hm1_reg)
                        begin
                            row_next    = '0;
                            rowf_next   = vf_reg ? hm1_reg : '0;
                            active_next = 1'b0;
                        end
                        else
                        begin
                            row_next  = row_reg + 1'b1;
                            rowf_next = vf_reg ? rowf_reg - 1'b1 : rowf_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next  = col_reg + 1'b1;
                        colf_next = hf_reg ? colf_reg - 1'b1 : colf_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                // unknown kind: consumed, nothing queued
                q_wr = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            col_reg    <= '0;
            row_reg    <= '0;
            colf_reg   <= '0;
            rowf_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            colf_reg   <= colf_next;
            rowf_reg   <= rowf_next;
        end
    end

    // object descriptor
    always_ff @(posedge clk)
    begin
        slot_reg    <= slot_next;
        slot_ok_reg <= slot_ok_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        wm1_reg     <= wm1_next;
        hm1_reg     <= hm1_next;
        hf_reg      <= hf_next;
        vf_reg      <= vf_next;
    end

endmodule

/* src/isb_queue.sv */
// Short request queue between front and back end.
`include "indexed_sprite_blitter_assert.svh"

module isb_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  isb_pkg::qentry_t  wr_data,
    output logic              full,
    input  logic              rd,
    output logic              nonempty,
    output isb_pkg::qentry_t  rd_data
);

    localparam int DEPTH = isb_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    isb_pkg::qentry_t slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_data  = slots_reg[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr && !rd)
            count_next = count_reg + 1'b1;
        else if (rd && !wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr)
            slots_reg[wr_ptr_reg] <= wr_data;
    end

    `ISB_ASSERT_IMP(a_no_overflow, clk, rst_n, wr, !full)
    `ISB_ASSERT_IMP(a_no_underflow, clk, rst_n, rd, nonempty)
    `ISB_ASSERT_NXT(a_fill_tracks, clk, rst_n, wr && !rd, count_reg == $past(count_reg) + 1'b1)

endmodule

/* src/isb_back.sv */
// Back end: palette stores, clipping, palette lookup and result register.
`include "indexed_sprite_blitter_assert.svh"

module isb_back #(
    parameter int NUM_PALETTES    = isb_pkg::NUM_PALETTES_DEF,
    parameter int PALETTE_ENTRIES = isb_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  isb_pkg::cfg_t     cfg,
    input  logic              q_nonempty,
    input  isb_pkg::qentry_t  q_data,
    output logic              q_rd,
    output logic              empty,
    input  logic              pop,
    output isb_pkg::result_t  result
);

    localparam int SLOT_AW = (NUM_PALETTES > 1) ? $clog2(NUM_PALETTES) : 1;
    localparam int COLOR_DEPTH = NUM_PALETTES * PALETTE_ENTRIES;
    localparam int CAD_W   = $clog2(COLOR_DEPTH);
    localparam int SIZE_W  = $clog2(PALETTE_ENTRIES + 1);
    localparam int CW      = isb_pkg::COORD_W;

    // palette stores
    logic [14:0]         color_mem [COLOR_DEPTH];
    logic [SIZE_W-1:0]   size_mem [NUM_PALETTES];
    logic [NUM_PALETTES-1:0] size_vld_reg;

    // issue stage signals
    logic                advance;
    logic [SLOT_AW-1:0]  slot_a;
    logic [CAD_W-1:0]    caddr;
    logic [CW-1:0]       dx_b1;
    logic [CW-1:0]       dy_b1;

    // lookup stage registers
    logic                b2_valid_reg;
    isb_pkg::op_t        b2_op_reg;
    logic                b2_slot_ok_reg;
    logic [7:0]          b2_idx_reg;
    logic [CW-1:0]       b2_dx_reg;
    logic [CW-1:0]       b2_dy_reg;
    logic                b2_vld_reg;
    logic [SIZE_W-1:0]   b2_size_reg;
    logic [14:0]         b2_color_reg;
    logic                skip_reg;

    // lookup stage decode
    logic [SIZE_W-1:0]   size_eff;
    logic                obj_skipped;
    logic                on_canvas;
    logic                pix_emit;
    logic                b2_emit;
    isb_pkg::result_t    res_b2;

    // result register
    logic                out_valid_reg;
    isb_pkg::result_t    out_reg;

    assign advance = !out_valid_reg || pop;
    assign q_rd    = advance && q_nonempty;
    assign slot_a  = SLOT_AW'(q_data.slot);
    assign caddr   = CAD_W'(32'(slot_a) * PALETTE_ENTRIES + 32'(q_data.idx));
    assign dx_b1   = q_data.wx - {{(CW-16){cfg.origin_x[15]}}, cfg.origin_x};
    assign dy_b1   = q_data.wy - {{(CW-16){cfg.origin_y[15]}}, cfg.origin_y};

    // colour store: at most one write or one read per request
    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            if (q_data.op == isb_pkg::OP_PAL)
            begin
                if (q_data.entry_ok)
                    color_mem[caddr] <= q_data.color;
            end
            else
                b2_color_reg <= color_mem[caddr];
        end
    end

    // size store
    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            if (q_data.op == isb_pkg::OP_PAL)
                size_mem[slot_a] <= SIZE_W'(q_data.size);
            else
                b2_size_reg <= size_mem[slot_a];
        end
    end

    // loaded flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_vld_reg <= '0;
        else if (q_rd && q_data.op == isb_pkg::OP_PAL)
            size_vld_reg[slot_a] <= 1'b1;
    end

    // lookup stage payload
    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            b2_op_reg      <= q_data.op;
            b2_slot_ok_reg <= q_data.slot_ok;
            b2_idx_reg     <= q_data.idx;
            b2_dx_reg      <= dx_b1;
            b2_dy_reg      <= dy_b1;
            b2_vld_reg     <= size_vld_reg[slot_a];
        end
    end

    // clip, transparency and palette range checks
    always_comb
    begin
        size_eff    = b2_vld_reg ? b2_size_reg : '0;
        obj_skipped = !b2_slot_ok_reg || (size_eff == '0);
        on_canvas   = !b2_dx_reg[CW-1] && !b2_dy_reg[CW-1]
                      && (b2_dx_reg < CW'(cfg.canvas_w))
                      && (b2_dy_reg < CW'(cfg.canvas_h));
        pix_emit    = !skip_reg && on_canvas && (b2_idx_reg != 8'd0)
                      && (9'(b2_idx_reg) < 9'(size_eff));

        res_b2 = '0;
        b2_emit = 1'b0;
        unique case (b2_op_reg)
            isb_pkg::OP_OBJ:
            begin
                b2_emit               = 1'b1;
                res_b2.is_status      = 1'b1;
                res_b2.object_skipped = obj_skipped;
            end
            isb_pkg::OP_PIX:
            begin
                b2_emit       = pix_emit;
                res_b2.dest_x = b2_dx_reg[12:0];
                res_b2.dest_y = b2_dy_reg[12:0];
                res_b2.red    = isb_pkg::expand5(b2_color_reg[14:10]);
                res_b2.green  = isb_pkg::expand5(b2_color_reg[9:5]);
                res_b2.blue   = isb_pkg::expand5(b2_color_reg[4:0]);
            end
            default:
            begin
                b2_emit = 1'b0;
            end
        endcase
    end

    // control: stage valid, object skip flag, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b2_valid_reg  <= 1'b0;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            b2_valid_reg  <= q_nonempty;
            out_valid_reg <= b2_valid_reg && b2_emit;
            if (b2_valid_reg && b2_op_reg == isb_pkg::OP_OBJ)
                skip_reg <= obj_skipped;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res_b2;
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    `ISB_ASSERT_IMP(a_dest_x_in_canvas, clk, rst_n, out_valid_reg && !out_reg.is_status, 14'(out_reg.dest_x) < cfg.canvas_w)
    `ISB_ASSERT_IMP(a_dest_y_in_canvas, clk, rst_n, out_valid_reg && !out_reg.is_status, 14'(out_reg.dest_y) < cfg.canvas_h)
    `ISB_ASSERT_IMP(a_status_clean, clk, rst_n, out_valid_reg && out_reg.is_status, out_reg.dest_x == 13'd0 && out_reg.red == 8'd0)

endmodule

/* src/indexed_sprite_blitter.sv */
// Top level of the palettized sprite blitter: ports, configuration, front/back.
//
//  channel   handshake              payload
//  -------   ---------------------  ------------------------------
//  input     push / full            item   (isb_pkg::item_t)
//  results   pop / empty            result (isb_pkg::result_t)
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per clock is taken and at most one result per clock is delivered
// when pop is held; a result passes the queue slot, the palette lookup stage and
// the result register on its way to the ports. The palette colour and size
// stores are each accessed once per request, which sets the rate at one per
// cycle.
// No clearing pass after reset: palette sizes carry per-slot loaded flags.
// A held result stalls the back end; full rises once the four-entry queue
// has filled behind it. cfg_ready is always high.
module indexed_sprite_blitter #(
    parameter int NUM_PALETTES    = isb_pkg::NUM_PALETTES_DEF,
    parameter int PALETTE_ENTRIES = isb_pkg::PALETTE_ENTRIES_DEF,
    parameter int MAX_IMAGE_DIM   = isb_pkg::MAX_IMAGE_DIM_DEF,
    parameter int MAX_CANVAS      = isb_pkg::MAX_CANVAS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  isb_pkg::item_t                  item,
    output logic                            empty,
    input  logic                            pop,
    output isb_pkg::result_t                result,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [isb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [isb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    isb_pkg::cfg_t    cfg_reg, cfg_next;
    logic [13:0]      dim_clamped;
    logic             q_wr;
    logic             q_rd;
    logic             q_full;
    logic             q_nonempty;
    isb_pkg::qentry_t q_wr_data;
    isb_pkg::qentry_t q_rd_data;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    // canvas size saturates at MAX_CANVAS
    assign dim_clamped = (cfg_data[13:0] > 14'(MAX_CANVAS)) ? 14'(MAX_CANVAS)
                                                            : cfg_data[13:0];

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                isb_pkg::CFG_ORIGIN_X:      cfg_next.origin_x = cfg_data;
                isb_pkg::CFG_ORIGIN_Y:      cfg_next.origin_y = cfg_data;
                isb_pkg::CFG_CANVAS_WIDTH:  cfg_next.canvas_w = dim_clamped;
                isb_pkg::CFG_CANVAS_HEIGHT: cfg_next.canvas_h = dim_clamped;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x <= '0;
            cfg_reg.origin_y <= '0;
            cfg_reg.canvas_w <= 14'(MAX_CANVAS);
            cfg_reg.canvas_h <= 14'(MAX_CANVAS);
        end
        else
            cfg_reg <= cfg_next;
    end

    isb_front #(
        .NUM_PALETTES    (NUM_PALETTES),
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .MAX_IMAGE_DIM   (MAX_IMAGE_DIM)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .item    (item),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_entry (q_wr_data)
    );

    isb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wr_data  (q_wr_data),
        .full     (q_full),
        .rd       (q_rd),
        .nonempty (q_nonempty),
        .rd_data  (q_rd_data)
    );

    isb_back #(
        .NUM_PALETTES    (NUM_PALETTES),
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_nonempty (q_nonempty),
        .q_data     (q_rd_data),
        .q_rd       (q_rd),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

endmodule

/* tb/tb_indexed_sprite_blitter.sv */
// Self-checking testbench for the indexed sprite blitter: directed table, then random sprites.
`timescale 1ns / 1ps

module tb_indexed_sprite_blitter;
    import isb_pkg::*;

    localparam int ENTRIES    = PALETTE_ENTRIES_DEF;
    localparam int IMG_MAX    = MAX_IMAGE_DIM_DEF;
    localparam int CANVAS_MAX = MAX_CANVAS_DEF;

    // kind code the block does not use; it must be ignored
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // one row of the directed table
    typedef struct packed {
        item_t   req;
        logic    typed;
        result_t want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    item_t       item = '0;
    logic        empty;
    logic        pop = 1'b0;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_ORIGIN_X;
    logic [15:0] cfg_data = '0;

    // predictor state: palettes
    logic [14:0] pal_color [256][256];
    bit          pal_written [256][256];
    int          pal_len [256];

    // predictor state: current sprite and raster position
    bit          spr_active;
    bit          spr_skipped;
    int          spr_slot;
    int          spr_x;
    int          spr_y;
    int          spr_w;
    int          spr_h;
    bit          spr_hflip;
    bit          spr_vflip;
    int          col_cnt;
    int          row_cnt;

    // predictor state: canvas registers
    int          org_x = 0;
    int          org_y = 0;
    int          canv_w = CANVAS_MAX;
    int          canv_h = CANVAS_MAX;

    result_t     owed_results[$];
    plan_row_t   directed_plan[$];
    int          fail_count = 0;
    int          phase_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    indexed_sprite_blitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // request builders; fields the kind does not use carry random junk
    // ---------------------------------------------------------------
    function automatic item_t filler_item();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        filler_item = raw[$bits(item_t)-1:0];
    endfunction

    function automatic item_t palette_write(input logic [7:0] slot, entry,
                                            input logic [14:0] color,
                                            input logic [8:0] size);
        item_t req;
        req = filler_item();
        req.kind = KIND_PAL;
        req.palette_slot = slot;
        req.entry = entry;
        req.color = color;
        req.pal_size = size;
        return req;
    endfunction

    function automatic item_t object_start(input logic [7:0] slot,
                                           input logic [15:0] px, py,
                                           input logic [12:0] w, h,
                                           input logic hf, vf);
        item_t req;
        req = filler_item();
        req.kind = KIND_OBJ;
        req.palette_slot = slot;
        req.pos_x = px;
        req.pos_y = py;
        req.img_width = w;
        req.img_height = h;
        req.hflip = hf;
        req.vflip = vf;
        return req;
    endfunction

    function automatic item_t pixel_item(input logic [7:0] v);
        item_t req;
        req = filler_item();
        req.kind = KIND_PIX;
        req.pixel = v;
        return req;
    endfunction

    function automatic result_t status_res(input logic skipped);
        result_t res;
        res = '0;
        res.is_status = 1'b1;
        res.object_skipped = skipped;
        return res;
    endfunction

    function automatic result_t pixel_res(input logic [12:0] x, y, input logic [7:0] r, g, b);
        result_t res;
        res = '0;
        res.dest_x = x;
        res.dest_y = y;
        res.red = r;
        res.green = g;
        res.blue = b;
        return res;
    endfunction

    function automatic plan_row_t plan_row(input item_t req, input logic typed,
                                           input result_t want);
        plan_row_t row;
        row.req = req;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    // append one row to the directed table
    function automatic void plan_add(input item_t req, input logic typed,
                                     input result_t want);
        directed_plan.insert(directed_plan.size(), plan_row(req, typed, want));
    endfunction

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // canvas position of the next pixel of the sprite; true when on canvas
    function automatic bit pixel_lands(output int dx, output int dy);
        int col;
        int row;
        col = col_cnt;
        row = row_cnt;
        if (spr_hflip)
            col = spr_w - 1 - col;
        if (spr_vflip)
            row = spr_h - 1 - row;
        dx = spr_x + col - org_x;
        dy = spr_y + row - org_y;
        return dx >= 0 && dy >= 0 && dx < canv_w && dy < canv_h;
    endfunction

    // true when this index would fetch a palette entry never written
    function automatic bit reads_blank_entry(input logic [7:0] v);
        int dx;
        int dy;
        if (!spr_active || spr_skipped || v == 0)
            return 0;
        if (!pixel_lands(dx, dy))
            return 0;
        return v < pal_len[spr_slot] && !pal_written[spr_slot][v];
    endfunction

    // updates the state for one request; returns 1 with the blit output if any
    function automatic bit blit_predict(input item_t req, output result_t res);
        int dx;
        int dy;
        int sz;
        bit hit;
        logic [14:0] c;
        res = '0;
        case (req.kind)
            KIND_PAL:
            begin
                sz = (req.pal_size > ENTRIES) ? ENTRIES : int'(req.pal_size);
                pal_color[req.palette_slot][req.entry] = req.color;
                pal_written[req.palette_slot][req.entry] = 1'b1;
                pal_len[req.palette_slot] = sz;
                return 0;
            end
            KIND_OBJ:
            begin
                spr_active = 1'b1;
                spr_slot = req.palette_slot;
                spr_skipped = (pal_len[spr_slot] == 0);
                spr_x = $signed(req.pos_x);
                spr_y = $signed(req.pos_y);
                spr_w = (req.img_width == 0) ? 1 :
                        (req.img_width > IMG_MAX) ? IMG_MAX : int'(req.img_width);
                spr_h = (req.img_height == 0) ? 1 :
                        (req.img_height > IMG_MAX) ? IMG_MAX : int'(req.img_height);
                spr_hflip = req.hflip;
                spr_vflip = req.vflip;
                col_cnt = 0;
                row_cnt = 0;
                res.is_status = 1'b1;
                res.object_skipped = spr_skipped;
                return 1;
            end
            KIND_PIX:
            begin
                if (!spr_active)
                    return 0;
                hit = pixel_lands(dx, dy);
                // advance the raster; the last pixel ends the sprite
                col_cnt++;
                if (col_cnt >= spr_w)
                begin
                    col_cnt = 0;
                    row_cnt++;
                    if (row_cnt >= spr_h)
                    begin
                        row_cnt = 0;
                        spr_active = 1'b0;
                    end
                end
                if (spr_skipped || !hit)
                    return 0;
                if (req.pixel == 0 || req.pixel >= pal_len[spr_slot])
                    return 0;
                c = pal_color[spr_slot][req.pixel];
                res.dest_x = dx[12:0];
                res.dest_y = dy[12:0];
                res.red = {c[14:10], c[14:12]};
                res.green = {c[9:5], c[9:7]};
                res.blue = {c[4:0], c[4:2]};
                return 1;
            end
            default:
                return 0;
        endcase
    endfunction

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------
    task automatic send_request(input item_t req, input logic typed, input result_t want);
        result_t res;
        bit gives;
        if (req.kind == KIND_PIX && reads_blank_entry(req.pixel))
            req.pixel = '0;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        item <= req;
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        // requests the block merely drops do not count toward the phase size
        if (!(req.kind == KIND_UNUSED || (req.kind == KIND_PIX && !spr_active)))
            phase_count++;
        gives = blit_predict(req, res);
        if (gives)
            owed_results.insert(owed_results.size(), typed ? want : res);
    endtask

    // hold off until every owed result is out and the pipeline is quiet
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ORIGIN_X:      org_x = $signed(val);
            CFG_ORIGIN_Y:      org_y = $signed(val);
            CFG_CANVAS_WIDTH:  canv_w = (val[13:0] > CANVAS_MAX) ? CANVAS_MAX : int'(val[13:0]);
            CFG_CANVAS_HEIGHT: canv_h = (val[13:0] > CANVAS_MAX) ? CANVAS_MAX : int'(val[13:0]);
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one well-formed sprite: palette load, start, raster of pixels
    task automatic send_sprite();
        int slot;
        int n;
        int sz;
        int e;
        int w;
        int h;
        int npix;
        int k;
        int r;
        int v;
        int off_x;
        int off_y;
        logic [12:0] w_raw;
        logic [12:0] h_raw;
        logic [15:0] px;
        logic [15:0] py;
        slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 7);

        // reload the palette now and then, always when it is not usable
        if (pal_len[slot] < 2 || $urandom_range(0, 1) == 0)
        begin
            n = ($urandom_range(0, 31) == 0) ? $urandom_range(2, ENTRIES) : $urandom_range(2, 12);
            sz = (n == ENTRIES && $urandom_range(0, 1) == 0) ?
                 $urandom_range(ENTRIES + 1, 511) : n;
            for (e = 1; e < n; e++)
                send_request(palette_write(8'(slot), 8'(e), 15'($urandom), 9'(sz)), 1'b0, '0);
        end

        // size, with the occasional zero or oversized dimension
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 6);
        w_raw = 13'(w);
        h_raw = 13'(h);
        case ($urandom_range(0, 19))
            0: begin w_raw = '0; w = 1; end
            1: begin h_raw = '0; h = 1; end
            2: begin w_raw = 13'($urandom_range(IMG_MAX + 1, 8191)); w = IMG_MAX; end
            3: begin h_raw = 13'($urandom_range(IMG_MAX + 1, 8191)); h = IMG_MAX; end
            default: ;
        endcase

        // mostly near the canvas so pixels straddle its edges
        if ($urandom_range(0, 7) == 0)
        begin
            px = 16'($urandom);
            py = 16'($urandom);
        end
        else
        begin
            off_x = int'($urandom_range(0, canv_w + w)) - w;
            off_y = int'($urandom_range(0, canv_h + h)) - h;
            px = 16'(org_x + off_x);
            py = 16'(org_y + off_y);
        end
        send_request(object_start(8'(slot), px, py, w_raw, h_raw, 1'($urandom), 1'($urandom)),
                     1'b0, '0);

        // full raster, or cut short, or with strays past the end
        npix = w * h;
        if (npix > 48)
            npix = $urandom_range(8, 48);
        r = $urandom_range(0, 9);
        if (r == 0)
            npix = $urandom_range(0, npix);
        else if (r == 1)
            npix = npix + $urandom_range(1, 3);
        for (k = 0; k < npix; k++)
        begin
            // palette rewritten under a live sprite
            if ($urandom_range(0, 39) == 0)
                send_request(palette_write(8'(slot), 8'($urandom_range(1, 255)), 15'($urandom),
                                           9'($urandom_range(0, pal_len[slot]))), 1'b0, '0);
            r = $urandom_range(0, 9);
            if (r == 0)
                v = 0;
            else if (r == 1 || pal_len[slot] < 2)
                v = $urandom_range(0, 255);
            else
                v = $urandom_range(1, pal_len[slot] - 1);
            send_request(pixel_item(8'(v)), 1'b0, '0);
        end
    endtask

    task automatic run_phase(input int quota);
        int k;
        int burst;
        phase_count = 0;
        while (phase_count < quota)
        begin
            if ($urandom_range(0, 4) != 0)
                send_sprite();
            else
            begin
                // noise: arbitrary requests of any kind
                burst = $urandom_range(1, 6);
                for (k = 0; k < burst; k++)
                    send_request(filler_item(), 1'b0, '0);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------
    always @(negedge clk)
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);

    function automatic string field_diffs(input result_t want, input result_t got);
        string d;
        d = "";
        if (got.is_status !== want.is_status)           d = {d, " is_status"};
        if (got.object_skipped !== want.object_skipped) d = {d, " object_skipped"};
        if (got.dest_x !== want.dest_x)                 d = {d, " dest_x"};
        if (got.dest_y !== want.dest_y)                 d = {d, " dest_y"};
        if (got.red !== want.red)                       d = {d, " red"};
        if (got.green !== want.green)                   d = {d, " green"};
        if (got.blue !== want.blue)                     d = {d, " blue"};
        return d;
    endfunction

    task automatic report_mismatch(input string what, input result_t want, input result_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s | exp st=%0b sk=%0b x=%0d y=%0d rgb=%h/%h/%h | got st=%0b sk=%0b x=%0d y=%0d rgb=%h/%h/%h",
                     $time, what,
                     want.is_status, want.object_skipped, want.dest_x, want.dest_y,
                     want.red, want.green, want.blue,
                     got.is_status, got.object_skipped, got.dest_x, got.dest_y,
                     got.red, got.green, got.blue);
    endtask

    // compare each popped result with the oldest owed one
    always @(posedge clk)
    begin : check_results
        result_t want;
        string diffs;
        if (rst_n && pop && !empty)
        begin
            if (owed_results.size() == 0)
                report_mismatch("unexpected result", '0, result);
            else
            begin
                want = owed_results.pop_front();
                diffs = field_diffs(want, result);
                if (diffs != "")
                    report_mismatch({"field mismatch:", diffs}, want, result);
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    initial
    begin : stimulus
        plan_row_t row;
        int k;
        int p;
        int quota;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [15:0] cw;
        logic [15:0] ch;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 6;
        recv_idle_pct = 50;

        // pixel before any sprite: ignored
        plan_add(pixel_item(8'd5), 1'b0, '0);
        // sprite on a palette never loaded: skipped, pixels consumed, stray ignored
        plan_add(object_start(8'd7, 16'd0, 16'd0, 13'd2, 13'd1, 1'b0, 1'b0),
                 1'b1, status_res(1'b1));
        plan_add(pixel_item(8'd1), 1'b0, '0);
        plan_add(pixel_item(8'd1), 1'b0, '0);
        plan_add(pixel_item(8'd1), 1'b0, '0);
        // size zero unloads the palette
        plan_add(palette_write(8'd200, 8'd1, 15'h7FFF, 9'd0), 1'b0, '0);
        plan_add(object_start(8'd200, 16'd0, 16'd0, 13'd1, 13'd1, 1'b0, 1'b0),
                 1'b1, status_res(1'b1));
        // oversized palette sizes saturate; top slot and top entry
        plan_add(palette_write(8'd255, 8'd255, 15'h7C00, 9'd511), 1'b0, '0);
        plan_add(palette_write(8'd255, 8'd1, 15'h7FFF, 9'd300), 1'b0, '0);
        plan_add(palette_write(8'd255, 8'd2, 15'h0000, 9'd256), 1'b0, '0);
        plan_add(palette_write(8'd0, 8'd1, 15'h03E0, 9'd2), 1'b0, '0);
        // zero width counts as one, oversized height saturates, both flips
        plan_add(object_start(8'd255, 16'd0, 16'd0, 13'd0, 13'd8191, 1'b1, 1'b1),
                 1'b1, status_res(1'b0));
        plan_add(pixel_item(8'd255), 1'b1,
                 pixel_res(13'd0, 13'd4095, 8'hFF, 8'h00, 8'h00));
        plan_add(pixel_item(8'd1), 1'b1,
                 pixel_res(13'd0, 13'd4094, 8'hFF, 8'hFF, 8'hFF));
        plan_add(pixel_item(8'd0), 1'b0, '0);
        plan_add(pixel_item(8'd2), 1'b1,
                 pixel_res(13'd0, 13'd4092, 8'h00, 8'h00, 8'h00));
        // extreme positions: far left is clipped, bottom-right corner lands
        plan_add(object_start(8'd0, 16'h8000, 16'h7FFF, 13'd8191, 13'd1, 1'b0, 1'b0),
                 1'b1, status_res(1'b0));
        plan_add(pixel_item(8'd1), 1'b0, '0);
        plan_add(object_start(8'd0, 16'd8191, 16'd8191, 13'd1, 13'd1, 1'b0, 1'b0),
                 1'b1, status_res(1'b0));
        plan_add(pixel_item(8'd1), 1'b1,
                 pixel_res(13'd8191, 13'd8191, 8'h00, 8'hFF, 8'h00));
        // horizontal flip; index at the palette size is dropped
        plan_add(object_start(8'd0, 16'd0, 16'd0, 13'd2, 13'd1, 1'b1, 1'b0),
                 1'b1, status_res(1'b0));
        plan_add(pixel_item(8'd2), 1'b0, '0);
        plan_add(pixel_item(8'd1), 1'b1,
                 pixel_res(13'd0, 13'd0, 8'h00, 8'hFF, 8'h00));
        // unused kind: ignored
        row = plan_row(filler_item(), 1'b0, '0);
        row.req.kind = KIND_UNUSED;
        plan_add(row.req, row.typed, row.want);

        for (k = 0; k < directed_plan.size(); k++)
        begin
            row = directed_plan[k];
            send_request(row.req, row.typed, row.want);
        end
        wait_idle();

        // random phases, each under its own canvas setting
        for (p = 0; p < 6; p++)
        begin
            send_idle_pct = (p < 2) ? 6 : (p < 4) ? 50 : 0;
            recv_idle_pct = (p < 2) ? 50 : (p < 4) ? 6 : 0;
            case (p)
                0:
                begin
                    ox = 16'd0; oy = 16'd0; cw = 16'd8192; ch = 16'd8192; quota = 170;
                end
                1:
                begin
                    ox = 16'h8000; oy = 16'h7FFF; cw = 16'd8192; ch = 16'd1; quota = 150;
                end
                2:
                begin
                    ox = 16'h7FFF; oy = 16'h8000; cw = 16'd1; ch = 16'd8192; quota = 150;
                end
                3:
                begin
                    ox = 16'($urandom); oy = 16'($urandom);
                    cw = {2'($urandom), 14'($urandom_range(1, 64))};
                    ch = {2'($urandom), 14'($urandom_range(1, 64))};
                    quota = 180;
                end
                4:
                begin
                    // width saturates, zero height drops everything
                    ox = 16'($urandom); oy = 16'($urandom);
                    cw = 16'h3FFF; ch = {2'($urandom), 14'd0};
                    quota = 60;
                end
                default:
                begin
                    ox = 16'($urandom_range(0, 200)) - 16'd100;
                    oy = 16'($urandom_range(0, 200)) - 16'd100;
                    cw = 16'($urandom_range(1, 300));
                    ch = 16'($urandom_range(1, 300));
                    quota = 220;
                end
            endcase
            write_register(CFG_ORIGIN_X, ox);
            write_register(CFG_ORIGIN_Y, oy);
            write_register(CFG_CANVAS_WIDTH, cw);
            write_register(CFG_CANVAS_HEIGHT, ch);
            run_phase(quota);
            wait_idle();
        end

        if (fail_count == 0 && owed_results.size() == 0)
            $display("indexed_sprite_blitter test passed");
        else
            $display("indexed_sprite_blitter test failed");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #500000;
        $display("indexed_sprite_blitter test failed");
        $finish;
    end

endmodule
